### hw/rtl/awpm_pkg.sv
// ----------------------------------------------------------------------------
// awpm_pkg: shared definitions for the ADC wave property meter
// Field widths, register indexes, reset values and the result item layout.
// ----------------------------------------------------------------------------
package awpm_pkg;

   // Fixed field widths of the ports.
   localparam int SAMPLE_W   = 10;
   localparam int RATE_W     = 20;
   localparam int START_THR_W = 10;
   localparam int FS_W       = 13;
   localparam int FREQ_W     = 19;
   localparam int PERIOD_W   = 20;
   localparam int AMP_W      = 13;
   localparam int DUTY_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // Defaults for the top level parameters.
   localparam int DEF_MAX_SAMPLES = 4096;
   localparam int DEF_SAMPLE_BITS = 10;

   // Register reset values.
   localparam logic [RATE_W-1:0]      RATE_RESET      = RATE_W'(125000);
   localparam logic [START_THR_W-1:0] START_THR_RESET = START_THR_W'(512);
   localparam logic [FS_W-1:0]        FS_RESET        = FS_W'(1500);

   // Arithmetic constants.
   localparam logic [FREQ_W-1:0]   FREQ_MAX    = {FREQ_W{1'b1}};
   localparam logic [PERIOD_W-1:0] PERIOD_NUM  = PERIOD_W'(1000000);
   localparam logic [DUTY_W-1:0]   DUTY_SCALE  = DUTY_W'(100);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_RATE = 2'd0,
      CSR_START_THR   = 2'd1,
      CSR_FULL_SCALE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [FREQ_W-1:0]   frequency_hz;
      logic [PERIOD_W-1:0] period_us;
      logic [AMP_W-1:0]    amplitude_mv;
      logic [DUTY_W-1:0]   duty_percent;
      logic                valid_res;
   } result_type;

endpackage

### hw/rtl/awpm_track.sv
// ----------------------------------------------------------------------------
// awpm_track: per-sample capture statistics
// Tracks peaks, adaptive threshold, high count and falling crossings.
// ----------------------------------------------------------------------------
module awpm_track
   import awpm_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int CNT_W       = $clog2(DEF_MAX_SAMPLES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [SAMPLE_BITS-1:0] code,
   input  logic [START_THR_W-1:0] start_thr,
   input  logic                   clear,
   output logic [CNT_W-1:0]       sample_count,
   output logic [SAMPLE_BITS-1:0] peak_max,
   output logic [SAMPLE_BITS:0]   peak_min,
   output logic [CNT_W-1:0]       high_count,
   output logic [CNT_W-1:0]       crossing_span,
   output logic [CNT_W-1:0]       crossing_count
);

   localparam int CMP_W = (SAMPLE_BITS > START_THR_W) ? SAMPLE_BITS : START_THR_W;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SAMPLE_BITS:0]   min_ff, min_in;
   logic [SAMPLE_BITS-1:0] thr_ff, thr_in;
   logic [CNT_W-1:0]       high_ff, high_in;
   logic [CNT_W-1:0]       lastpos_ff, lastpos_in;
   logic [CNT_W-1:0]       span_ff, span_in;
   logic [CNT_W-1:0]       cross_ff, cross_in;
   logic                   was_high_ff, was_high_in;

   logic [CNT_W-1:0]       count_next;
   logic [CMP_W-1:0]       thr_cmp;
   logic                   is_high;
   logic [SAMPLE_BITS+1:0] mid_sum;

   always_comb begin
      count_in    = count_ff;
      max_in      = max_ff;
      min_in      = min_ff;
      thr_in      = thr_ff;
      high_in     = high_ff;
      lastpos_in  = lastpos_ff;
      span_in     = span_ff;
      cross_in    = cross_ff;
      was_high_in = was_high_ff;

      count_next = count_ff + CNT_W'(1);
      // Before the first sample the start register is used as it is now.
      thr_cmp    = (count_ff == '0) ? CMP_W'(start_thr) : CMP_W'(thr_ff);
      is_high    = CMP_W'(code) > thr_cmp;
      mid_sum    = '0;

      if (clear) begin
         count_in    = '0;
         max_in      = '0;
         min_in      = {1'b1, {SAMPLE_BITS{1'b0}}};
         thr_in      = '0;
         high_in     = '0;
         lastpos_in  = '0;
         span_in     = '0;
         cross_in    = '0;
         was_high_in = 1'b0;
      end else if (take && (count_ff < CNT_W'(MAX_SAMPLES))) begin
         count_in = count_next;
         if (code > max_ff) begin
            max_in = code;
         end
         if ({1'b0, code} < min_ff) begin
            min_in = {1'b0, code};
         end
         if (is_high) begin
            high_in = high_ff + CNT_W'(1);
         end
         if (was_high_ff && !is_high) begin
            if (cross_ff != '0) begin
               span_in = span_ff + (count_next - lastpos_ff);
            end
            lastpos_in = count_next;
            cross_in   = cross_ff + CNT_W'(1);
         end
         was_high_in = is_high;
         // The minimum is below full range once a sample is in, so the
         // midpoint fits the code width.
         mid_sum = (SAMPLE_BITS + 2)'(max_in) + (SAMPLE_BITS + 2)'(min_in);
         thr_in  = mid_sum[SAMPLE_BITS:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         max_ff      <= '0;
         min_ff      <= {1'b1, {SAMPLE_BITS{1'b0}}};
         thr_ff      <= '0;
         high_ff     <= '0;
         lastpos_ff  <= '0;
         span_ff     <= '0;
         cross_ff    <= '0;
         was_high_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         max_ff      <= max_in;
         min_ff      <= min_in;
         thr_ff      <= thr_in;
         high_ff     <= high_in;
         lastpos_ff  <= lastpos_in;
         span_ff     <= span_in;
         cross_ff    <= cross_in;
         was_high_ff <= was_high_in;
      end
   end

   assign sample_count   = count_ff;
   assign peak_max       = max_ff;
   assign peak_min       = min_ff;
   assign high_count     = high_ff;
   assign crossing_span  = span_ff;
   assign crossing_count = cross_ff;

endmodule

### hw/rtl/awpm_div.sv
// ----------------------------------------------------------------------------
// awpm_div: shared iterative divider
// Restoring division, one quotient bit per cycle, with a done pulse.
// ----------------------------------------------------------------------------
module awpm_div
   import awpm_pkg::*;
#(
   parameter int NUM_W = RATE_W + 13,
   parameter int DEN_W = FREQ_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DEN_W:0]    shifted;
   logic [DEN_W:0]    diff;
   logic              fits;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};

      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

### hw/rtl/awpm_seq.sv
// ----------------------------------------------------------------------------
// awpm_seq: result sequencer
// Drives the shared multiplier and divider to form the result item.
// ----------------------------------------------------------------------------
module awpm_seq
   import awpm_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int CNT_W       = $clog2(DEF_MAX_SAMPLES + 1),
   parameter int MUL_B_W     = 13,
   parameter int NUM_W       = RATE_W + 13,
   parameter int DEN_W       = FREQ_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [RATE_W-1:0]      sample_rate,
   input  logic [FS_W-1:0]        full_scale,
   input  logic [CNT_W-1:0]       sample_count,
   input  logic [SAMPLE_BITS-1:0] peak_max,
   input  logic [SAMPLE_BITS:0]   peak_min,
   input  logic [CNT_W-1:0]       high_count,
   input  logic [CNT_W-1:0]       crossing_span,
   input  logic [CNT_W-1:0]       crossing_count,
   output logic                   div_start,
   output logic [NUM_W-1:0]       div_num,
   output logic [DEN_W-1:0]       div_den,
   input  logic                   div_done,
   input  logic [NUM_W-1:0]       div_quot,
   output logic                   idle,
   output logic                   res_valid,
   output result_type             res,
   input  logic                   res_take
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FREQ_GO,
      ST_FREQ_WAIT,
      ST_PER_GO,
      ST_PER_WAIT,
      ST_DUTY_GO,
      ST_DUTY_WAIT,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [NUM_W-1:0]    prod_ff, prod_in;
   result_type          res_ff, res_in;

   logic [RATE_W-1:0]      mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [NUM_W-1:0]       mul_prod;
   logic [SAMPLE_BITS-1:0] peak_diff;
   logic [FREQ_W-1:0]      freq_sat;

   assign peak_diff = peak_max - peak_min[SAMPLE_BITS-1:0];

   // Operand select for the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_CHECK: begin
            mul_a = sample_rate;
            mul_b = MUL_B_W'(crossing_count - CNT_W'(1));
         end
         ST_PER_GO: begin
            mul_a = RATE_W'(full_scale);
            mul_b = MUL_B_W'(peak_diff);
         end
         default: begin
            mul_a = RATE_W'(DUTY_SCALE);
            mul_b = MUL_B_W'(high_count);
         end
      endcase
   end

   assign mul_prod = NUM_W'(mul_a) * NUM_W'(mul_b);

   assign freq_sat = (div_quot > NUM_W'(FREQ_MAX)) ? FREQ_MAX : div_quot[FREQ_W-1:0];

   assign div_start = (state_ff == ST_FREQ_GO) || (state_ff == ST_PER_GO) ||
                      (state_ff == ST_DUTY_GO);
   assign div_num   = (state_ff == ST_PER_GO) ? NUM_W'(PERIOD_NUM) : prod_ff;

   always_comb begin
      case (state_ff)
         ST_FREQ_GO: div_den = DEN_W'(crossing_span);
         ST_PER_GO:  div_den = DEN_W'(res_ff.frequency_hz);
         default:    div_den = DEN_W'(sample_count);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      res_in   = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((crossing_count >= CNT_W'(2)) && (crossing_span != '0)) begin
               prod_in  = mul_prod;
               state_in = ST_FREQ_GO;
            end else begin
               res_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_FREQ_GO: begin
            state_in = ST_FREQ_WAIT;
         end
         ST_FREQ_WAIT: begin
            if (div_done) begin
               if (freq_sat == '0) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  res_in.frequency_hz = freq_sat;
                  state_in            = ST_PER_GO;
               end
            end
         end
         ST_PER_GO: begin
            prod_in  = mul_prod;
            state_in = ST_PER_WAIT;
         end
         ST_PER_WAIT: begin
            if (div_done) begin
               res_in.period_us    = div_quot[PERIOD_W-1:0];
               res_in.amplitude_mv = prod_ff[SAMPLE_BITS +: AMP_W];
               prod_in             = mul_prod;
               state_in            = ST_DUTY_GO;
            end
         end
         ST_DUTY_GO: begin
            state_in = ST_DUTY_WAIT;
         end
         ST_DUTY_WAIT: begin
            if (div_done) begin
               res_in.duty_percent = div_quot[DUTY_W-1:0];
               res_in.valid_res    = 1'b1;
               state_in            = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

endmodule

### hw/rtl/adc_wave_property_meter_top.sv
// ----------------------------------------------------------------------------
// adc_wave_property_meter_top: wave frequency, period, amplitude and duty meter
// Measures one capture of ADC samples and reports one result item per capture.
// ----------------------------------------------------------------------------
// Each accepted sample item updates the running peaks, the adaptive threshold
// (floor midpoint of max and min, starting from the start_threshold register),
// the high-sample count and the falling-crossing statistics in registers, so
// while the sequencer is idle samples stream in at one item per clock. An item
// with is_last set closes the capture: the block then stalls its input while a
// small sequencer drives one multiplier and one shared restoring divider (one
// quotient bit per cycle) through three divisions: frequency, period and duty,
// with an N-bit numerator, N = 20 + max(count bits, SAMPLE_BITS, 7). After a
// crossing check the result item waits in the sequencer until it is handed to
// the output register, from which it shows up on rsp_. A capture with fewer
// than two crossings finishes with an all-zero result item; one whose
// frequency floors to zero stops after the first division, also with an
// all-zero result item. The result sits in an output register, so the next
// capture's samples are taken while it waits to be collected, and the capture
// statistics clear as the result is handed over. If that register is still
// occupied when the next result is finished, the input stays stalled until the
// receiver takes the older one. Samples beyond MAX_SAMPLES are ignored, though
// is_last on such a sample still closes the capture. Configuration registers
// are written through the csr_ port; the user must write them only while no
// capture result is being computed, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module adc_wave_property_meter_top
   import awpm_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  logic                  req_is_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [FREQ_W-1:0]     rsp_frequency_hz,
   output logic [PERIOD_W-1:0]   rsp_period_us,
   output logic [AMP_W-1:0]      rsp_amplitude_mv,
   output logic [DUTY_W-1:0]     rsp_duty_percent,
   output logic                  rsp_valid_res,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Counter width holds MAX_SAMPLES itself.
   localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int MB_A    = (CNT_W > SAMPLE_BITS) ? CNT_W : SAMPLE_BITS;
   localparam int MUL_B_W = (MB_A > DUTY_W) ? MB_A : DUTY_W;
   localparam int NUM_W   = RATE_W + MUL_B_W;
   localparam int DEN_W   = (CNT_W > FREQ_W) ? CNT_W : FREQ_W;

   // Configuration registers.
   logic [RATE_W-1:0]      rate_ff, rate_in;
   logic [START_THR_W-1:0] start_thr_ff, start_thr_in;
   logic [FS_W-1:0]        fs_ff, fs_in;

   always_comb begin
      rate_in      = rate_ff;
      start_thr_in = start_thr_ff;
      fs_in        = fs_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SAMPLE_RATE: rate_in      = csr_wdata[RATE_W-1:0];
            CSR_START_THR:   start_thr_in = csr_wdata[START_THR_W-1:0];
            CSR_FULL_SCALE:  fs_in        = csr_wdata[FS_W-1:0];
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff      <= RATE_RESET;
         start_thr_ff <= START_THR_RESET;
         fs_ff        <= FS_RESET;
      end else begin
         rate_ff      <= rate_in;
         start_thr_ff <= start_thr_in;
         fs_ff        <= fs_in;
      end
   end

   // Input handshake: samples flow whenever the sequencer is idle.
   logic seq_idle;
   logic sample_take;

   assign req_stall   = !seq_idle;
   assign sample_take = req_valid && !req_stall;

   logic [CNT_W-1:0]       sample_count;
   logic [SAMPLE_BITS-1:0] peak_max;
   logic [SAMPLE_BITS:0]   peak_min;
   logic [CNT_W-1:0]       high_count;
   logic [CNT_W-1:0]       crossing_span;
   logic [CNT_W-1:0]       crossing_count;
   logic                   res_valid;
   logic                   res_take;
   result_type             res;

   awpm_track #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_SAMPLES (MAX_SAMPLES),
      .CNT_W       (CNT_W)
   ) u_track (
      .clock          (clock),
      .reset          (reset),
      .take           (sample_take),
      .code           (SAMPLE_BITS'(req_sample)),
      .start_thr      (start_thr_ff),
      .clear          (res_take),
      .sample_count   (sample_count),
      .peak_max       (peak_max),
      .peak_min       (peak_min),
      .high_count     (high_count),
      .crossing_span  (crossing_span),
      .crossing_count (crossing_count)
   );

   logic             div_start;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic             div_done;
   logic [NUM_W-1:0] div_quot;

   awpm_seq #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .MUL_B_W     (MUL_B_W),
      .NUM_W       (NUM_W),
      .DEN_W       (DEN_W)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (sample_take && req_is_last),
      .sample_rate    (rate_ff),
      .full_scale     (fs_ff),
      .sample_count   (sample_count),
      .peak_max       (peak_max),
      .peak_min       (peak_min),
      .high_count     (high_count),
      .crossing_span  (crossing_span),
      .crossing_count (crossing_count),
      .div_start      (div_start),
      .div_num        (div_num),
      .div_den        (div_den),
      .div_done       (div_done),
      .div_quot       (div_quot),
      .idle           (seq_idle),
      .res_valid      (res_valid),
      .res            (res),
      .res_take       (res_take)
   );

   awpm_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Output register: a finished result moves in when the slot is free or
   // is being emptied in the same cycle.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_res_ff, rsp_res_in;

   assign res_take     = res_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);
   assign rsp_res_in   = res_take ? res : rsp_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frequency_hz = rsp_res_ff.frequency_hz;
   assign rsp_period_us    = rsp_res_ff.period_us;
   assign rsp_amplitude_mv = rsp_res_ff.amplitude_mv;
   assign rsp_duty_percent = rsp_res_ff.duty_percent;
   assign rsp_valid_res    = rsp_res_ff.valid_res;

endmodule

### hw/rtl/awpm_checker.sv
// ----------------------------------------------------------------------------
// awpm_checker: port-level checks for the wave property meter
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module awpm_checker
   import awpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_is_last,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [FREQ_W-1:0]     rsp_frequency_hz,
   input  logic [PERIOD_W-1:0]   rsp_period_us,
   input  logic [AMP_W-1:0]      rsp_amplitude_mv,
   input  logic [DUTY_W-1:0]     rsp_duty_percent,
   input  logic                  rsp_valid_res
);

   // A stalled result item stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // Closing a capture stops sample intake while the result is computed.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_is_last |=> req_stall)
      else $error("input not stalled after the last sample");

   // An invalid result carries zero in every field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |->
         (rsp_frequency_hz == '0) && (rsp_period_us == '0) &&
         (rsp_amplitude_mv == '0) && (rsp_duty_percent == '0))
      else $error("invalid result with nonzero fields");

   // A valid result has a nonzero frequency, a nonzero period and a duty in range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |->
         (rsp_frequency_hz != '0) && (rsp_period_us != '0) &&
         (rsp_duty_percent <= DUTY_SCALE))
      else $error("valid result out of range");

endmodule

bind adc_wave_property_meter_top awpm_checker u_awpm_checker (.*);
